[sv/zsse_pkg.sv]
`default_nettype none
package zsse_pkg;

    localparam int DIM_BITS_DEF    = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [15:0] BLOCK_MAX = 16'hFFFF;
    localparam logic [16:0] ADLER_MOD = 17'd65521;
    localparam logic [7:0]  ZLIB_CMF  = 8'h78;
    localparam logic [7:0]  ZLIB_FLG  = 8'h01;

    // register indexes on the configuration port
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PIXEL_MODE   = 2'd2;

    // pixel modes
    localparam logic [2:0] MODE_GRAY = 3'd0;
    localparam logic [2:0] MODE_RGB  = 3'd1;
    localparam logic [2:0] MODE_BIT1 = 3'd2;
    localparam logic [2:0] MODE_BIT2 = 3'd3;
    localparam logic [2:0] MODE_BIT4 = 3'd4;

    // byte slots of one item, in stream order
    localparam int POS_CMF  = 0;
    localparam int POS_FLG  = 1;
    localparam int POS_FBH  = 2;
    localparam int POS_FILT = 7;
    localparam int POS_DBH  = 8;
    localparam int POS_DATA = 13;
    localparam int POS_TRL  = 14;
    localparam int POS_LAST = 17;
    localparam int NPOS     = 18;

    typedef logic [NPOS-1:0] zsse_mask_t;

    // what one accepted item asks the back end to emit
    typedef struct packed {
        logic        hdr;
        logic        filt;
        logic        bh_filt;
        logic        data;
        logic        bh_data;
        logic        trailer;
        logic        bh_final;
        logic [15:0] bh_len;
        logic [7:0]  data_byte;
    } zsse_desc_t;

endpackage
`default_nettype wire

[sv/zlib_stored_stream_encoder.sv]
`default_nettype none
// Image-to-zlib encoder using stored deflate blocks. Samples enter in row
// order, one per cycle unless stalled, and leave as bytes of a zlib stream:
// header 78 01, a zero filter byte before each row, a 5-byte stored block
// header every 65535 data bytes (the last one marked final with its true
// length), and a big-endian Adler-32 trailer flagged by stream_end. In 1, 2
// and 4 bit modes indexes are packed MSB first and a row's partial byte is
// zero padded. The front end takes one sample per cycle while in_stall is
// low and hands a descriptor to a queue of QUEUE_DEPTH entries; the back end
// emits one byte per cycle while out_stall is low, expanding each item into
// its bytes (one for a plain data byte, up to 13 at a stream start, row
// start, block boundary or stream end). The output byte rate is the limit:
// in_stall rises only when the queue is full. Write the geometry registers
// between streams; writes while a stream is open are dropped.
module zlib_stored_stream_encoder #(
    parameter int DIM_BITS    = zsse_pkg::DIM_BITS_DEF,
    parameter int QUEUE_DEPTH = zsse_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // sample input
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  sample,
    // byte output
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             run_last,
    output logic             stream_end
);

    logic                      stream_open;
    logic [2:0]                pbits;
    logic [DIM_BITS+1:0]       spr;
    logic [DIM_BITS-1:0]       height_eff;
    logic [2*DIM_BITS+1:0]     total;
    logic                      q_full, q_valid, push, pop;
    zsse_pkg::zsse_desc_t      push_desc, q_desc;

    assign pready = 1'b1;

    // register file plus geometry derived from it
    zsse_regs #(
        .DIM_BITS (DIM_BITS)
    ) u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .stream_open (stream_open),
        .pbits       (pbits),
        .spr         (spr),
        .height_eff  (height_eff),
        .total       (total)
    );

    // classify each sample: which headers, filter, data and trailer bytes
    zsse_front #(
        .DIM_BITS (DIM_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .pbits       (pbits),
        .spr         (spr),
        .height_eff  (height_eff),
        .total       (total),
        .stream_open (stream_open),
        .q_full      (q_full),
        .push        (push),
        .push_desc   (push_desc)
    );

    // hold descriptors while the back end works through byte bursts
    zsse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_desc    (q_desc)
    );

    // expand descriptors to bytes, one per cycle while out_stall is low, and keep the checksum
    zsse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_desc     (q_desc),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .stream_end (stream_end)
    );

endmodule
`default_nettype wire

[sv/zsse_regs.sv]
`default_nettype none
module zsse_regs #(
    parameter int DIM_BITS = zsse_pkg::DIM_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [3:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic      [31:0]             prdata,
    input  wire logic                    stream_open,
    output logic      [2:0]              pbits,
    output logic      [DIM_BITS+1:0]     spr,
    output logic      [DIM_BITS-1:0]     height_eff,
    output logic      [2*DIM_BITS+1:0]   total
);

    localparam int SW  = DIM_BITS + 2;
    localparam int BLW = 2 * DIM_BITS + 2;

    logic [DIM_BITS-1:0] width_reg, width_next;
    logic [DIM_BITS-1:0] height_reg, height_next;
    logic [2:0]          mode_reg, mode_next;
    logic [2:0]          pbits_reg, pbits_next;
    logic [SW-1:0]       spr_reg, spr_next;
    logic [DIM_BITS-1:0] heff_reg, heff_next;
    logic [BLW-1:0]      total_reg, total_next;

    logic                wr;
    logic [DIM_BITS-1:0] w_eff;
    logic [2:0]          mode_eff;
    logic [DIM_BITS+2:0] wbits;
    logic [DIM_BITS+2:0] wbits_rnd;
    logic [SW-1:0]       rdb;

    assign wr = psel && penable && pwrite && !stream_open;

    // derived geometry follows the registers in the same edge
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        mode_next   = mode_reg;
        if (wr)
        begin
            case (paddr[3:2])
                zsse_pkg::REG_IMAGE_WIDTH:  width_next  = pwdata[DIM_BITS-1:0];
                zsse_pkg::REG_IMAGE_HEIGHT: height_next = pwdata[DIM_BITS-1:0];
                zsse_pkg::REG_PIXEL_MODE:   mode_next   = pwdata[2:0];
                default:                    ;
            endcase
        end

        w_eff     = (width_next == '0) ? DIM_BITS'(1) : width_next;
        heff_next = (height_next == '0) ? DIM_BITS'(1) : height_next;
        mode_eff  = (mode_next > zsse_pkg::MODE_BIT4) ? zsse_pkg::MODE_GRAY : mode_next;

        case (mode_eff)
            zsse_pkg::MODE_BIT1: pbits_next = 3'd1;
            zsse_pkg::MODE_BIT2: pbits_next = 3'd2;
            zsse_pkg::MODE_BIT4: pbits_next = 3'd4;
            default:             pbits_next = 3'd0;
        endcase

        if (mode_eff == zsse_pkg::MODE_RGB)
            spr_next = {2'b00, w_eff} + {1'b0, w_eff, 1'b0};
        else
            spr_next = {2'b00, w_eff};

        case (pbits_next)
            3'd1:    wbits = {3'b000, w_eff};
            3'd2:    wbits = {2'b00, w_eff, 1'b0};
            3'd4:    wbits = {1'b0, w_eff, 2'b00};
            default: wbits = '0;
        endcase
        wbits_rnd = wbits + (DIM_BITS+3)'(7);

        if (pbits_next == 3'd0)
            rdb = spr_next;
        else
            rdb = {2'b00, wbits_rnd[DIM_BITS+2:3]};

        total_next = {{(BLW-DIM_BITS){1'b0}}, heff_next}
                   * {{(BLW-SW){1'b0}}, rdb + SW'(1)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_BITS'(1);
            height_reg <= DIM_BITS'(1);
            mode_reg   <= zsse_pkg::MODE_GRAY;
            pbits_reg  <= 3'd0;
            spr_reg    <= SW'(1);
            heff_reg   <= DIM_BITS'(1);
            total_reg  <= BLW'(2);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            mode_reg   <= mode_next;
            pbits_reg  <= pbits_next;
            spr_reg    <= spr_next;
            heff_reg   <= heff_next;
            total_reg  <= total_next;
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            zsse_pkg::REG_IMAGE_WIDTH:  prdata = {{(32-DIM_BITS){1'b0}}, width_reg};
            zsse_pkg::REG_IMAGE_HEIGHT: prdata = {{(32-DIM_BITS){1'b0}}, height_reg};
            zsse_pkg::REG_PIXEL_MODE:   prdata = {29'd0, mode_reg};
            default:                    prdata = '0;
        endcase
    end

    assign pbits      = pbits_reg;
    assign spr        = spr_reg;
    assign height_eff = heff_reg;
    assign total      = total_reg;

endmodule
`default_nettype wire

[sv/zsse_front.sv]
`default_nettype none
module zsse_front #(
    parameter int DIM_BITS = zsse_pkg::DIM_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            sample,
    input  wire logic [2:0]            pbits,
    input  wire logic [DIM_BITS+1:0]   spr,
    input  wire logic [DIM_BITS-1:0]   height_eff,
    input  wire logic [2*DIM_BITS+1:0] total,
    output logic                       stream_open,
    input  wire logic                  q_full,
    output logic                       push,
    output zsse_pkg::zsse_desc_t       push_desc
);

    localparam int SW  = DIM_BITS + 2;
    localparam int BLW = 2 * DIM_BITS + 2;
    localparam logic [BLW-1:0] BLK_MAX_W = {{(BLW-16){1'b0}}, zsse_pkg::BLOCK_MAX};

    logic                header_sent_reg, header_sent_next;
    logic [DIM_BITS-1:0] row_reg, row_next;
    logic [SW-1:0]       sir_reg, sir_next;
    logic [7:0]          pbuf_reg, pbuf_next;
    logic [2:0]          pcnt_reg, pcnt_next;
    logic [15:0]         bpos_reg, bpos_next;
    logic [BLW-1:0]      bleft_reg, bleft_next;

    logic                accept;
    logic                hdr, filt, bh_filt, data, bh_data, trailer;
    logic [BLW-1:0]      bl0, bl1, bl2, bh_sel;
    logic [15:0]         bp1, bp2;
    logic [SW-1:0]       sir_inc;
    logic                row_end;
    logic [DIM_BITS-1:0] row_inc;
    logic                packed_mode;
    logic [7:0]          pbuf_new;
    logic [3:0]          pcnt_new;
    logic [3:0]          used;
    logic [3:0]          shamt;
    logic [7:0]          packed_byte;

    function automatic logic [15:0] bp_inc(input logic [15:0] bp);
        return (bp == zsse_pkg::BLOCK_MAX - 16'd1) ? 16'd0 : bp + 16'd1;
    endfunction

    function automatic logic [BLW-1:0] bl_dec(input logic [BLW-1:0] bl);
        return (bl == '0) ? bl : bl - BLW'(1);
    endfunction

    assign in_stall    = q_full;
    assign accept      = in_valid && !q_full;
    assign stream_open = header_sent_reg;

    always_comb
    begin
        hdr     = !header_sent_reg;
        bl0     = hdr ? total : bleft_reg;
        filt    = (sir_reg == '0);
        bh_filt = filt && (bpos_reg == 16'd0);
        bp1     = filt ? bp_inc(bpos_reg) : bpos_reg;
        bl1     = filt ? bl_dec(bl0) : bl0;

        sir_inc = sir_reg + SW'(1);
        row_end = (sir_inc >= spr);

        // pack low index bits MSB first
        packed_mode = (pbits != 3'd0);
        pcnt_new    = {1'b0, pcnt_reg} + 4'd1;
        case (pbits)
            3'd1:
            begin
                pbuf_new = {pbuf_reg[6:0], sample[0]};
                used     = pcnt_new;
            end
            3'd2:
            begin
                pbuf_new = {pbuf_reg[5:0], sample[1:0]};
                used     = {pcnt_new[2:0], 1'b0};
            end
            3'd4:
            begin
                pbuf_new = {pbuf_reg[3:0], sample[3:0]};
                used     = {pcnt_new[1:0], 2'b00};
            end
            default:
            begin
                pbuf_new = pbuf_reg;
                used     = 4'd0;
            end
        endcase
        shamt       = 4'd8 - used;
        packed_byte = pbuf_new << shamt;

        data    = packed_mode ? ((used >= 4'd8) || row_end) : 1'b1;
        bh_data = data && (bp1 == 16'd0);
        bp2     = data ? bp_inc(bp1) : bp1;
        bl2     = data ? bl_dec(bl1) : bl1;

        bh_sel  = bh_filt ? bl0 : bl1;

        row_inc = row_reg + DIM_BITS'(1);
        trailer = row_end && (row_inc >= height_eff);

        push_desc.hdr       = hdr;
        push_desc.filt      = filt;
        push_desc.bh_filt   = bh_filt;
        push_desc.data      = data;
        push_desc.bh_data   = bh_data;
        push_desc.trailer   = trailer;
        push_desc.bh_final  = (bh_sel <= BLK_MAX_W);
        push_desc.bh_len    = (bh_sel < BLK_MAX_W) ? bh_sel[15:0] : zsse_pkg::BLOCK_MAX;
        push_desc.data_byte = packed_mode ? packed_byte : sample;

        push = accept && (hdr || filt || data);

        header_sent_next = header_sent_reg;
        row_next         = row_reg;
        sir_next         = sir_reg;
        pbuf_next        = pbuf_reg;
        pcnt_next        = pcnt_reg;
        bpos_next        = bpos_reg;
        bleft_next       = bleft_reg;
        if (accept)
        begin
            if (trailer)
            begin
                header_sent_next = 1'b0;
                row_next         = '0;
                sir_next         = '0;
                pbuf_next        = 8'd0;
                pcnt_next        = 3'd0;
                bpos_next        = 16'd0;
                bleft_next       = '0;
            end
            else
            begin
                header_sent_next = 1'b1;
                bpos_next        = bp2;
                bleft_next       = bl2;
                sir_next         = row_end ? '0 : sir_inc;
                row_next         = row_end ? row_inc : row_reg;
                if (packed_mode)
                begin
                    pbuf_next = data ? 8'd0 : pbuf_new;
                    pcnt_next = data ? 3'd0 : pcnt_new[2:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_sent_reg <= 1'b0;
            row_reg         <= '0;
            sir_reg         <= '0;
            pbuf_reg        <= 8'd0;
            pcnt_reg        <= 3'd0;
            bpos_reg        <= 16'd0;
            bleft_reg       <= '0;
        end
        else
        begin
            header_sent_reg <= header_sent_next;
            row_reg         <= row_next;
            sir_reg         <= sir_next;
            pbuf_reg        <= pbuf_next;
            pcnt_reg        <= pcnt_next;
            bpos_reg        <= bpos_next;
            bleft_reg       <= bleft_next;
        end
    end

endmodule
`default_nettype wire

[sv/zsse_queue.sv]
`default_nettype none
module zsse_queue #(
    parameter int DEPTH = zsse_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire zsse_pkg::zsse_desc_t push_desc,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      q_valid,
    output zsse_pkg::zsse_desc_t      q_desc
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    zsse_pkg::zsse_desc_t slot_reg [DEPTH];
    logic [AW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 do_push, do_pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign full    = (count_reg == CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_desc  = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

[sv/zsse_back.sv]
`default_nettype none
module zsse_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire zsse_pkg::zsse_desc_t q_desc,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [7:0]                out_byte,
    output logic                      run_last,
    output logic                      stream_end
);

    zsse_pkg::zsse_mask_t mask_reg, mask_next;
    zsse_pkg::zsse_desc_t desc_reg, desc_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        run_last_reg, run_last_next;
    logic        stream_end_reg, stream_end_next;
    logic [15:0] adler_low_reg, adler_low_next;
    logic [15:0] adler_high_reg, adler_high_next;

    logic                 adv, have, emit;
    zsse_pkg::zsse_mask_t lowbit, rest, load_mask;
    logic [4:0]           idx;
    logic [7:0]           byte_sel;
    logic                 is_data;
    logic [15:0]          nlen;
    logic [16:0]          low_sum, high_sum;
    logic [15:0]          low_upd, high_upd;

    always_comb
    begin
        adv    = !out_valid_reg || !out_stall;
        have   = (mask_reg != '0);
        lowbit = mask_reg & (~mask_reg + zsse_pkg::zsse_mask_t'(1));
        rest   = mask_reg & ~lowbit;
        emit   = adv && have;
        pop    = adv && q_valid && (!have || (rest == '0));

        load_mask = {{4{q_desc.trailer}}, q_desc.data, {5{q_desc.bh_data}},
                     q_desc.filt, {5{q_desc.bh_filt}}, q_desc.hdr, q_desc.hdr};

        idx = 5'd0;
        for (int i = zsse_pkg::NPOS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                idx = 5'(i);
        end

        nlen    = ~desc_reg.bh_len;
        is_data = 1'b0;
        case (idx)
            zsse_pkg::POS_CMF:                       byte_sel = zsse_pkg::ZLIB_CMF;
            zsse_pkg::POS_FLG:                       byte_sel = zsse_pkg::ZLIB_FLG;
            zsse_pkg::POS_FBH, zsse_pkg::POS_DBH:    byte_sel = {7'd0, desc_reg.bh_final};
            zsse_pkg::POS_FBH + 1, zsse_pkg::POS_DBH + 1:
                                                     byte_sel = desc_reg.bh_len[7:0];
            zsse_pkg::POS_FBH + 2, zsse_pkg::POS_DBH + 2:
                                                     byte_sel = desc_reg.bh_len[15:8];
            zsse_pkg::POS_FBH + 3, zsse_pkg::POS_DBH + 3:
                                                     byte_sel = nlen[7:0];
            zsse_pkg::POS_FBH + 4, zsse_pkg::POS_DBH + 4:
                                                     byte_sel = nlen[15:8];
            zsse_pkg::POS_FILT:
            begin
                byte_sel = 8'd0;
                is_data  = 1'b1;
            end
            zsse_pkg::POS_DATA:
            begin
                byte_sel = desc_reg.data_byte;
                is_data  = 1'b1;
            end
            zsse_pkg::POS_TRL:                       byte_sel = adler_high_reg[15:8];
            zsse_pkg::POS_TRL + 1:                   byte_sel = adler_high_reg[7:0];
            zsse_pkg::POS_TRL + 2:                   byte_sel = adler_low_reg[15:8];
            zsse_pkg::POS_LAST:                      byte_sel = adler_low_reg[7:0];
            default:                                 byte_sel = 8'd0;
        endcase

        // Adler-32 step, both sums kept below the modulus
        low_sum  = {1'b0, adler_low_reg} + {9'd0, byte_sel};
        low_upd  = (low_sum >= zsse_pkg::ADLER_MOD) ? 16'(low_sum - zsse_pkg::ADLER_MOD)
                                                    : low_sum[15:0];
        high_sum = {1'b0, adler_high_reg} + {1'b0, low_upd};
        high_upd = (high_sum >= zsse_pkg::ADLER_MOD) ? 16'(high_sum - zsse_pkg::ADLER_MOD)
                                                     : high_sum[15:0];

        adler_low_next  = adler_low_reg;
        adler_high_next = adler_high_reg;
        if (emit && is_data)
        begin
            adler_low_next  = low_upd;
            adler_high_next = high_upd;
        end
        else if (emit && (idx == 5'(zsse_pkg::POS_LAST)))
        begin
            adler_low_next  = 16'd1;
            adler_high_next = 16'd0;
        end

        if (pop)
            mask_next = load_mask;
        else if (emit)
            mask_next = rest;
        else
            mask_next = mask_reg;
        desc_next = pop ? q_desc : desc_reg;

        out_valid_next  = adv ? have : out_valid_reg;
        out_byte_next   = emit ? byte_sel : out_byte_reg;
        run_last_next   = emit ? (rest == '0) : run_last_reg;
        stream_end_next = emit ? (idx == 5'(zsse_pkg::POS_LAST)) : stream_end_reg;
    end

    always_ff @(posedge clk)
    begin
        desc_reg     <= desc_next;
        out_byte_reg <= out_byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg       <= '0;
            out_valid_reg  <= 1'b0;
            run_last_reg   <= 1'b0;
            stream_end_reg <= 1'b0;
            adler_low_reg  <= 16'd1;
            adler_high_reg <= 16'd0;
        end
        else
        begin
            mask_reg       <= mask_next;
            out_valid_reg  <= out_valid_next;
            run_last_reg   <= run_last_next;
            stream_end_reg <= stream_end_next;
            adler_low_reg  <= adler_low_next;
            adler_high_reg <= adler_high_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign run_last   = run_last_reg;
    assign stream_end = stream_end_reg;

endmodule
`default_nettype wire

[test/zlib_stored_stream_encoder_tb.sv]
`default_nettype none
module zlib_stored_stream_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Register byte addresses on the configuration port (index times four).
    localparam logic [3:0] ADDR_W     = {zsse_pkg::REG_IMAGE_WIDTH, 2'b00};
    localparam logic [3:0] ADDR_H     = {zsse_pkg::REG_IMAGE_HEIGHT, 2'b00};
    localparam logic [3:0] ADDR_MODE  = {zsse_pkg::REG_PIXEL_MODE, 2'b00};
    localparam logic [3:0] ADDR_SPARE = 4'hC;   // one past the register list

    // Idle cycles after the last expected byte, so a stray extra byte is
    // still caught before the next configuration.
    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_HOLD     = 300;
    // Slowest legal run: about 250 items at up to 13 bytes each behind a
    // receiver that stalls 58 percent of the time, plus three register writes
    // and a drain per image; the limit allows several times that.
    localparam int LIMIT_CYCLES  = 200_000;

    typedef struct {
        logic [7:0] b;
        logic       last;
        logic       fin;
    } zbyte_t;

    typedef enum logic [1:0] {STEP_WRITE, STEP_SAMPLE, STEP_DRAIN} step_kind_t;

    typedef struct {
        step_kind_t    kind;
        logic [3:0]    addr;
        logic [31:0]   data;    // register value, or the sample in the low byte
        int            want_n;  // typed-in stream bytes, 0 to use the predictor
        logic [103:0]  want;    // first byte in the top octet
    } step_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    wire  [31:0] prdata;
    wire         pready;
    logic        in_valid;
    wire         in_stall;
    logic [7:0]  sample;
    wire         out_valid;
    logic        out_stall = 1'b0;
    wire  [7:0]  out_byte;
    wire         run_last;
    wire         stream_end;

    // Typed-in expectation travels with the sample it belongs to.
    int           typed_n;
    logic [103:0] typed_bytes;

    // Knobs for the receiver process.
    int recv_idle_pct = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    int send_idle_pct;
    int cycle_count     = 0;
    int error_count     = 0;
    int items_accepted  = 0;
    int bytes_checked   = 0;
    int streams_done    = 0;

    zbyte_t zlib_expect_q[$];
    zbyte_t step_bytes_q[$];
    step_t  plan[$];

    // Predictor copy of the configuration.
    logic [15:0] cfg_w;
    logic [15:0] cfg_h;
    logic [2:0]  cfg_mode;

    // Predictor copy of the stream state.
    bit              hdr_open;
    int unsigned     row_cnt;
    int unsigned     col_cnt;
    int unsigned     pack_acc;
    int unsigned     pack_n;
    int unsigned     blk_pos;
    longint unsigned remain;
    int unsigned     ad_lo;
    int unsigned     ad_hi;

    zlib_stored_stream_encoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .stream_end (stream_end)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void stream_clear();
        hdr_open = 1'b0;
        row_cnt  = 0;
        col_cnt  = 0;
        pack_acc = 0;
        pack_n   = 0;
        blk_pos  = 0;
        remain   = 0;
        ad_lo    = 1;
        ad_hi    = 0;
    endfunction

    function automatic void emit_byte(logic [7:0] b, logic fin);
        zbyte_t z;
        z.b    = b;
        z.last = 1'b0;
        z.fin  = fin;
        step_bytes_q.push_back(z);
    endfunction

    // One data byte: open a stored block first where one is due, then fold
    // the byte into the running Adler-32.
    function automatic void emit_data_byte(logic [7:0] b);
        logic [15:0] len;
        if (blk_pos == 0)
        begin
            len = (remain < zsse_pkg::BLOCK_MAX) ? remain[15:0] : zsse_pkg::BLOCK_MAX;
            emit_byte((remain <= zsse_pkg::BLOCK_MAX) ? 8'd1 : 8'd0, 1'b0);
            emit_byte(len[7:0], 1'b0);
            emit_byte(len[15:8], 1'b0);
            emit_byte(~len[7:0], 1'b0);
            emit_byte(~len[15:8], 1'b0);
        end
        emit_byte(b, 1'b0);
        ad_lo = ad_lo + b;
        if (ad_lo >= zsse_pkg::ADLER_MOD)
            ad_lo = ad_lo - zsse_pkg::ADLER_MOD;
        ad_hi = ad_hi + ad_lo;
        if (ad_hi >= zsse_pkg::ADLER_MOD)
            ad_hi = ad_hi - zsse_pkg::ADLER_MOD;
        blk_pos = (blk_pos + 1) % zsse_pkg::BLOCK_MAX;
        if (remain != 0)
            remain = remain - 1;
    endfunction

    // Work out the stream bytes one accepted sample causes into step_bytes_q.
    function automatic void zlib_predict_sample(logic [7:0] s);
        logic [2:0]  mode;
        int unsigned ew;
        int unsigned eh;
        int unsigned bits;
        int unsigned per;
        int unsigned row_samples;
        longint unsigned row_bytes;
        bit          row_end;
        zbyte_t      z;

        mode = (cfg_mode > zsse_pkg::MODE_BIT4) ? zsse_pkg::MODE_GRAY : cfg_mode;
        ew   = (cfg_w == 0) ? 1 : cfg_w;
        eh   = (cfg_h == 0) ? 1 : cfg_h;
        bits = (mode == zsse_pkg::MODE_BIT1) ? 1 :
               (mode == zsse_pkg::MODE_BIT2) ? 2 :
               (mode == zsse_pkg::MODE_BIT4) ? 4 : 0;
        row_samples = (mode == zsse_pkg::MODE_RGB) ? 3 * ew : ew;
        row_bytes   = (bits == 0) ? row_samples : (ew * bits + 7) / 8;

        if (!hdr_open)
        begin
            hdr_open = 1'b1;
            remain   = longint'(eh) * (1 + row_bytes);
            emit_byte(zsse_pkg::ZLIB_CMF, 1'b0);
            emit_byte(zsse_pkg::ZLIB_FLG, 1'b0);
        end
        if (col_cnt == 0)
            emit_data_byte(8'h00);     // row filter: none

        row_end = (col_cnt + 1) >= row_samples;

        if (bits == 0)
            emit_data_byte(s);
        else
        begin
            per      = 8 / bits;
            pack_acc = ((pack_acc << bits) | (s & ((1 << bits) - 1))) & 8'hFF;
            pack_n   = pack_n + 1;
            if (pack_n >= per || row_end)
            begin
                // pad a short byte at row end with zero bits on the right
                emit_data_byte(8'((pack_acc << ((per - pack_n) * bits)) & 8'hFF));
                pack_acc = 0;
                pack_n   = 0;
            end
        end

        if (row_end)
        begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1) & 16'hFFFF;
            if (row_cnt >= eh)
            begin
                emit_byte(8'(ad_hi >> 8), 1'b0);
                emit_byte(8'(ad_hi), 1'b0);
                emit_byte(8'(ad_lo >> 8), 1'b0);
                emit_byte(8'(ad_lo), 1'b1);
                stream_clear();
            end
        end
        else
            col_cnt = (col_cnt + 1) & 18'h3FFFF;

        if (step_bytes_q.size() > 0)
        begin
            z      = step_bytes_q.pop_back();
            z.last = 1'b1;
            step_bytes_q.push_back(z);
        end
    endfunction

    // Register write as the block sees it: dropped while a stream is open.
    function automatic void zlib_cfg_write(logic [3:0] addr, logic [31:0] data);
        if (hdr_open)
            return;
        case (addr[3:2])
            zsse_pkg::REG_IMAGE_WIDTH:  cfg_w    = data[15:0];
            zsse_pkg::REG_IMAGE_HEIGHT: cfg_h    = data[15:0];
            zsse_pkg::REG_PIXEL_MODE:   cfg_mode = data[2:0];
            default: ;
        endcase
    endfunction

    function automatic void flag_error(string msg);
        error_count = error_count + 1;
        if (error_count <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------
    // Checker: compare each accepted byte against the oldest expectation,
    // then predict for a sample accepted at this edge. Bytes of a sample
    // accepted now cannot leave before the next edge, so this order holds.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        zbyte_t want;
        zbyte_t z;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                bytes_checked = bytes_checked + 1;
                if (zlib_expect_q.size() == 0)
                    flag_error($sformatf("byte %02h with nothing expected", out_byte));
                else
                begin
                    want = zlib_expect_q.pop_front();
                    if (out_byte !== want.b || run_last !== want.last
                        || stream_end !== want.fin)
                        flag_error($sformatf(
                            "byte/run_last/stream_end expected %02h/%b/%b got %02h/%b/%b",
                            want.b, want.last, want.fin, out_byte, run_last, stream_end));
                    if (want.fin)
                        streams_done = streams_done + 1;
                end
            end

            if (in_valid && !in_stall)
            begin
                items_accepted = items_accepted + 1;
                step_bytes_q.delete();
                zlib_predict_sample(sample);
                // a typed-in row stands for one whole stream: keep the
                // predictor state moving but expect the typed bytes
                if (typed_n != 0)
                begin
                    step_bytes_q.delete();
                    for (int i = 0; i < typed_n; i++)
                    begin
                        z.b    = typed_bytes[8 * (typed_n - 1 - i) +: 8];
                        z.last = (i == typed_n - 1);
                        z.fin  = (i == typed_n - 1);
                        step_bytes_q.push_back(z);
                    end
                end
                foreach (step_bytes_q[i])
                    zlib_expect_q.push_back(step_bytes_q[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall, or a long hold-off when one is requested.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d bytes still expected",
                     cycle_count, zlib_expect_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic void add_step(step_kind_t k, logic [3:0] a = '0, logic [31:0] d = '0,
                                     int n = 0, logic [103:0] w = '0);
        step_t st;
        st.kind   = k;
        st.addr   = a;
        st.data   = d;
        st.want_n = n;
        st.want   = w;
        plan.push_back(st);
    endfunction

    // Two-phase write; then idle with psel low so back-to-back writes never
    // lower and raise psel in the same step.
    task automatic write_reg(logic [3:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        zlib_cfg_write(addr, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one sample, idling first at the current rate; hold it until taken.
    task automatic send_sample(logic [7:0] s, int n, logic [103:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        sample      <= s;
        typed_n     <= n;
        typed_bytes <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop offering, wait for every expected byte, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (zlib_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Configure and stream one whole image of random samples. At probe_at,
    // drain mid-stream and try a register write that the block must drop.
    task automatic run_image(logic [15:0] w, logic [15:0] h, logic [2:0] mode,
                             int probe_at, output int total);
        int ew;
        int eh;
        ew    = (w == 0) ? 1 : w;
        eh    = (h == 0) ? 1 : h;
        total = ew * eh * ((mode == zsse_pkg::MODE_RGB) ? 3 : 1);
        write_reg(ADDR_MODE, {29'($urandom), mode});
        write_reg(ADDR_W, {16'($urandom), w});
        write_reg(ADDR_H, {16'($urandom), h});
        for (int k = 0; k < total; k++)
        begin
            if (k == probe_at)
            begin
                drain();
                write_reg({2'($urandom), 2'b00}, $urandom);
            end
            send_sample(8'($urandom), 0, '0);
        end
        drain();
    endtask

    // Random small images until about the given number of items went in.
    task automatic random_phase(int items);
        int          sent;
        int          n;
        int          probe;
        logic [15:0] w;
        logic [15:0] h;
        logic [2:0]  m;
        sent = 0;
        while (sent < items)
        begin
            m = 3'($urandom_range(7));
            w = 16'($urandom_range(6));
            h = 16'($urandom_range(3));
            probe = ($urandom_range(7) == 0) ? $urandom_range(4, 1) : -1;
            run_image(w, h, m, probe, n);
            sent = sent + n;
        end
    endtask

    initial
    begin
        int n;

        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        sample      = '0;
        typed_n     = 0;
        typed_bytes = '0;
        send_idle_pct = 0;
        cfg_w    = 16'd1;
        cfg_h    = 16'd1;
        cfg_mode = zsse_pkg::MODE_GRAY;
        stream_clear();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. After reset the image is one gray pixel, so each
        // sample is a whole stream: header, final block of two bytes, filter,
        // the sample and the Adler-32.
        add_step(STEP_SAMPLE, '0, 32'hFF, 13, 104'h78_01_01_02_00_FD_FF_00_FF_01_01_01_00);
        add_step(STEP_SAMPLE, '0, 32'h00, 13, 104'h78_01_01_02_00_FD_FF_00_00_00_02_00_01);
        add_step(STEP_DRAIN);
        // write past the register list, high bits beyond the width, zero
        // height, and a mode above the defined ones
        add_step(STEP_WRITE, ADDR_SPARE, 32'hFFFF_FFFF);
        add_step(STEP_WRITE, ADDR_W, 32'hFFFF_0002);
        add_step(STEP_WRITE, ADDR_H, 32'h0000_0000);
        add_step(STEP_WRITE, ADDR_MODE, 32'h0000_0007);
        add_step(STEP_SAMPLE, '0, 32'hA5);
        add_step(STEP_SAMPLE, '0, 32'h5A);
        add_step(STEP_DRAIN);
        // RGB, two rows of one pixel
        add_step(STEP_WRITE, ADDR_MODE, {29'd0, zsse_pkg::MODE_RGB});
        add_step(STEP_WRITE, ADDR_W, 32'd1);
        add_step(STEP_WRITE, ADDR_H, 32'd2);
        add_step(STEP_SAMPLE, '0, 32'h80);
        add_step(STEP_SAMPLE, '0, 32'h7F);
        add_step(STEP_SAMPLE, '0, 32'h01);
        add_step(STEP_SAMPLE, '0, 32'hFE);
        add_step(STEP_SAMPLE, '0, 32'h55);
        add_step(STEP_SAMPLE, '0, 32'hAA);
        add_step(STEP_DRAIN);
        // 1-bit: three pixels, high sample bits ignored, short byte padded
        add_step(STEP_WRITE, ADDR_MODE, {29'd0, zsse_pkg::MODE_BIT1});
        add_step(STEP_WRITE, ADDR_W, 32'd3);
        add_step(STEP_WRITE, ADDR_H, 32'd1);
        add_step(STEP_SAMPLE, '0, 32'hFF);
        add_step(STEP_SAMPLE, '0, 32'hFE);
        add_step(STEP_SAMPLE, '0, 32'h01);
        add_step(STEP_DRAIN);
        // 2-bit: one full byte and one padded
        add_step(STEP_WRITE, ADDR_MODE, {29'd0, zsse_pkg::MODE_BIT2});
        add_step(STEP_WRITE, ADDR_W, 32'd5);
        add_step(STEP_SAMPLE, '0, 32'hFF);
        add_step(STEP_SAMPLE, '0, 32'h02);
        add_step(STEP_SAMPLE, '0, 32'hFD);
        add_step(STEP_SAMPLE, '0, 32'h00);
        add_step(STEP_SAMPLE, '0, 32'h03);
        add_step(STEP_DRAIN);
        // 4-bit, two rows of three; a width write mid-stream must be dropped
        add_step(STEP_WRITE, ADDR_MODE, {29'd0, zsse_pkg::MODE_BIT4});
        add_step(STEP_WRITE, ADDR_W, 32'd3);
        add_step(STEP_WRITE, ADDR_H, 32'd2);
        add_step(STEP_SAMPLE, '0, 32'hF0);
        add_step(STEP_SAMPLE, '0, 32'h0F);
        add_step(STEP_DRAIN);
        add_step(STEP_WRITE, ADDR_W, 32'd1);
        add_step(STEP_SAMPLE, '0, 32'hA7);
        add_step(STEP_SAMPLE, '0, 32'h5C);
        add_step(STEP_SAMPLE, '0, 32'h3B);
        add_step(STEP_SAMPLE, '0, 32'hFF);
        add_step(STEP_DRAIN);

        foreach (plan[i])
        begin
            case (plan[i].kind)
                STEP_WRITE:  write_reg(plan[i].addr, plan[i].data);
                STEP_SAMPLE: send_sample(plan[i].data[7:0], plan[i].want_n, plan[i].want);
                STEP_DRAIN:  drain();
                default: ;
            endcase
        end

        // Sender idles lightly, receiver heavily. Open with a long receiver
        // hold-off under a 24-pixel row so the queue fills and in_stall rises.
        send_idle_pct = 19;
        recv_idle_pct <= 58;
        hold_req      <= hold_req + 1;
        run_image(16'd24, 16'd1, zsse_pkg::MODE_GRAY, -1, n);
        random_phase(55);

        // Swap the idle rates.
        send_idle_pct = 58;
        recv_idle_pct <= 19;
        random_phase(60);

        // No idling on either side.
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        random_phase(60);

        $display("Ran %0d items into %0d checked bytes over %0d streams in %0d cycles:",
                 items_accepted, bytes_checked, streams_done, cycle_count);
        $display("all pixel modes, row padding, dropped writes, long hold-off, idle mixes.");
        if (error_count == 0 && zlib_expect_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            $display("%0d mismatches, %0d bytes never seen", error_count, zlib_expect_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
